[sv/rfbs_pkg.sv]
// Shared knob codes and digit types for the radio frequency BCD stepper.
package rfbs_pkg;

  typedef enum logic [1:0] {
    KNOB_COM_MHZ  = 2'd0,
    KNOB_COM_FRAC = 2'd1,
    KNOB_NAV_MHZ  = 2'd2,
    KNOB_NAV_FRAC = 2'd3
  } knob_e;

  typedef logic [3:0] digit_t;

  localparam int unsigned FreqWidth = 16;

endpackage

[sv/radio_frequency_bcd_stepper.sv]
// Top level of the radio frequency BCD stepper: input register, stepper, result register.
// Each accepted word is stepped from the input register into the result register.
// Throughput: one word per cycle while not stalled; the input and result registers each
// hold a word, so input is taken while a finished result still waits downstream.
// Reset clears both valid flags; the payload registers are not reset.
module radio_frequency_bcd_stepper import rfbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic                 step_down_i,
  input  logic [FreqWidth-1:0] freq_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FreqWidth-1:0] new_freq_word_o
);

  logic                 s1_valid_q;
  logic [1:0]           s1_type_q;
  logic                 s1_down_q;
  logic [FreqWidth-1:0] s1_word_q;
  logic [FreqWidth-1:0] step_word;
  logic                 out_valid_q;
  logic [FreqWidth-1:0] out_word_q;
  logic                 out_busy;
  logic                 out_load;

  assign out_busy   = out_valid_q && out_stall_i;
  assign out_load   = s1_valid_q && !out_busy;
  assign in_stall_o = s1_valid_q && out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_type_q <= req_type_i;
      s1_down_q <= step_down_i;
      s1_word_q <= freq_word_i;
    end
  end

  rfbs_step u_step (
    .req_type_i      (s1_type_q),
    .step_down_i     (s1_down_q),
    .freq_word_i     (s1_word_q),
    .new_freq_word_o (step_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= step_word;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_freq_word_o = out_word_q;

endmodule

[sv/rfbs_step.sv]
// Combinational one-notch stepper for a four-digit BCD frequency word.
module rfbs_step import rfbs_pkg::*; (
  input  logic [1:0]           req_type_i,
  input  logic                 step_down_i,
  input  logic [FreqWidth-1:0] freq_word_i,
  output logic [FreqWidth-1:0] new_freq_word_o
);

  function automatic logic [7:0] step_mhz(input digit_t hi_in, input digit_t lo_in,
                                          input logic down, input logic nav);
    digit_t hi;
    digit_t lo;
    hi = hi_in;
    lo = lo_in;
    if (!down) begin
      if (lo < 4'd9) begin
        lo = lo + 4'd1;
      end else if (lo == 4'd9) begin
        lo = 4'd0;
        hi = hi + 4'd1;
      end
      if (!nav && hi == 4'd3 && lo == 4'd7) begin
        hi = 4'd1;
        lo = 4'd8;
      end
      if (nav && hi == 4'd1 && lo == 4'd8) begin
        hi = 4'd0;
        lo = 4'd8;
      end
    end else begin
      if (lo != 4'd0) begin
        lo = lo - 4'd1;
      end else begin
        lo = 4'd9;
        hi = hi - 4'd1;
      end
      if (!nav && hi == 4'd1 && lo == 4'd7) begin
        hi = 4'd3;
        lo = 4'd6;
      end
      if (nav && hi == 4'd0 && lo == 4'd7) begin
        hi = 4'd1;
        lo = 4'd7;
      end
    end
    return {hi, lo};
  endfunction

  function automatic logic [7:0] step_com_frac(input digit_t hi_in, input digit_t lo_in,
                                               input logic down);
    digit_t     hi;
    digit_t     lo;
    logic       a;
    logic       b;
    logic [2:0] delta;
    logic [4:0] sum;
    hi = hi_in;
    lo = lo_in;
    a  = (lo == 4'd0) || (lo == 4'd5);
    b  = (lo == 4'd2) || (lo == 4'd7);
    if (!down) begin
      delta = a ? 3'd2 : (b ? 3'd3 : 3'd0);
      sum   = {1'b0, lo} + {2'b00, delta};
      if (sum < 5'd10) begin
        lo = sum[3:0];
      end else if (sum == 5'd10) begin
        lo = 4'd0;
        hi = hi + 4'd1;
      end
      if (hi == 4'd10) begin
        hi = 4'd0;
        lo = 4'd0;
      end
    end else begin
      delta = a ? 3'd3 : (b ? 3'd2 : 3'd0);
      sum   = '0;
      if (lo >= {1'b0, delta}) begin
        lo = lo - {1'b0, delta};
      end else begin
        lo = 4'd7;
        hi = (hi == 4'd0) ? 4'd9 : hi - 4'd1;
      end
    end
    return {hi, lo} ^ {3'b000, sum[4], 4'b0000} ^ {3'b000, sum[4], 4'b0000};
  endfunction

  function automatic logic [7:0] step_nav_frac(input digit_t hi_in, input digit_t lo_in,
                                               input logic down);
    digit_t hi;
    digit_t lo;
    hi = hi_in;
    lo = lo_in;
    if (!down) begin
      if (lo < 4'd5) begin
        lo = lo + 4'd5;
      end else if (lo == 4'd5) begin
        lo = 4'd0;
        hi = hi + 4'd1;
      end
      if (hi == 4'd10) begin
        hi = 4'd0;
        lo = 4'd0;
      end
    end else begin
      if (lo >= 4'd5) begin
        lo = lo - 4'd5;
      end else if (lo == 4'd0) begin
        lo = 4'd5;
        hi = (hi == 4'd0) ? 4'd9 : hi - 4'd1;
      end
    end
    return {hi, lo};
  endfunction

  knob_e knob;

  assign knob = knob_e'(req_type_i);

  always_comb begin
    new_freq_word_o = freq_word_i;
    unique case (knob)
      KNOB_COM_MHZ:  new_freq_word_o[15:8] = step_mhz(freq_word_i[15:12], freq_word_i[11:8],
                                                      step_down_i, 1'b0);
      KNOB_NAV_MHZ:  new_freq_word_o[15:8] = step_mhz(freq_word_i[15:12], freq_word_i[11:8],
                                                      step_down_i, 1'b1);
      KNOB_COM_FRAC: new_freq_word_o[7:0] = step_com_frac(freq_word_i[7:4], freq_word_i[3:0],
                                                          step_down_i);
      KNOB_NAV_FRAC: new_freq_word_o[7:0] = step_nav_frac(freq_word_i[7:4], freq_word_i[3:0],
                                                          step_down_i);
      default:       new_freq_word_o = freq_word_i;
    endcase
  end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the radio frequency BCD stepper.
module testbench;
  import rfbs_pkg::*;

  localparam int unsigned RandomWords = 1800;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct {
    knob_e                knob;
    logic                 down;
    logic [FreqWidth-1:0] word;
    int unsigned          gap;
    bit                   drain;
  } tune_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i = 2'd0;
  logic                 step_down_i = 1'b0;
  logic [FreqWidth-1:0] freq_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [FreqWidth-1:0] new_freq_word_o;

  tune_req_t            tune_req_q[$];
  logic [FreqWidth-1:0] expected_freq_q[$];
  tune_req_t            next_req;
  logic                 in_fire = 1'b0;
  logic                 out_fire = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          words_taken = 0;
  int unsigned          words_total = 0;
  int unsigned          cycles = 0;
  int unsigned          errors = 0;

  radio_frequency_bcd_stepper i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .step_down_i    (step_down_i),
    .freq_word_i    (freq_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_freq_word_o(new_freq_word_o)
  );

  function automatic logic [FreqWidth-1:0] step_freq(knob_e knob, logic down,
                                                     logic [FreqWidth-1:0] word);
    int unsigned hi;
    int unsigned lo;
    int unsigned delta;
    logic [FreqWidth-1:0] stepped;
    stepped = word;
    if (knob == KNOB_COM_MHZ || knob == KNOB_NAV_MHZ) begin
      hi = 32'(word[15:12]);
      lo = 32'(word[11:8]);
      if (!down) begin
        if (lo < 9) begin
          lo++;
        end else if (lo == 9) begin
          lo = 0;
          hi = (hi + 1) % 16;
        end
        if (knob == KNOB_COM_MHZ && hi == 3 && lo == 7) begin
          hi = 1;
          lo = 8;
        end
        if (knob == KNOB_NAV_MHZ && hi == 1 && lo == 8) begin
          hi = 0;
          lo = 8;
        end
      end else begin
        if (lo >= 1) begin
          lo--;
        end else begin
          lo = 9;
          hi = (hi + 15) % 16;
        end
        if (knob == KNOB_COM_MHZ && hi == 1 && lo == 7) begin
          hi = 3;
          lo = 6;
        end
        if (knob == KNOB_NAV_MHZ && hi == 0 && lo == 7) begin
          hi = 1;
          lo = 7;
        end
      end
      stepped[15:8] = {4'(hi), 4'(lo)};
    end else begin
      hi = 32'(word[7:4]);
      lo = 32'(word[3:0]);
      if (knob == KNOB_COM_FRAC) begin
        if (lo == 0 || lo == 5) begin
          delta = down ? 3 : 2;
        end else if (lo == 2 || lo == 7) begin
          delta = down ? 2 : 3;
        end else begin
          delta = 0;
        end
      end else begin
        delta = 5;
      end
      if (!down) begin
        if (lo + delta < 10) begin
          lo += delta;
        end else if (lo + delta == 10) begin
          lo = 0;
          hi = (hi + 1) % 16;
        end
        if (hi == 10) begin
          hi = 0;
          lo = 0;
        end
      end else if (lo >= delta) begin
        lo -= delta;
      end else if (lo == 0) begin
        lo = (knob == KNOB_COM_FRAC) ? 7 : 5;
        hi = (hi == 0) ? 9 : hi - 1;
      end
      stepped[7:0] = {4'(hi), 4'(lo)};
    end
    return stepped;
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned value);
    return {4'(value / 10), 4'(value % 10)};
  endfunction

  // Draw a frequency on the band of the knob: COM on the 25 kHz raster, NAV on 50 kHz.
  function automatic logic [FreqWidth-1:0] tuned_word(knob_e knob);
    int unsigned mhz;
    int unsigned frac;
    if (knob == KNOB_COM_MHZ || knob == KNOB_COM_FRAC) begin
      mhz  = $urandom_range(18, 36);
      frac = 10 * $urandom_range(0, 9) + ($urandom_range(0, 1) ? 5 : 0)
             + ($urandom_range(0, 1) ? 2 : 0);
    end else begin
      mhz  = $urandom_range(8, 17);
      frac = 10 * $urandom_range(0, 9) + ($urandom_range(0, 1) ? 5 : 0);
    end
    return {to_bcd(mhz), to_bcd(frac)};
  endfunction

  function automatic int unsigned draw_stall();
    return ((cycles / 700) % 3 == 0) ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic queue_req(knob_e knob, logic down, logic [FreqWidth-1:0] word,
                           int unsigned gap, bit drain);
    tune_req_t req;
    req.knob  = knob;
    req.down  = down;
    req.word  = word;
    req.gap   = gap;
    req.drain = drain;
    tune_req_q.push_back(req);
    words_total++;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("radio_frequency_bcd_stepper verification failed");
    $finish;
  end

  // Drive one word at a time; hold it until taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (tune_req_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (tune_req_q[0].gap > 0) begin
        tune_req_q[0].gap = tune_req_q[0].gap - 1;
        in_valid_i <= 1'b0;
      end else if (tune_req_q[0].drain && expected_freq_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        next_req = tune_req_q.pop_front();
        req_type_i  <= next_req.knob;
        step_down_i <= next_req.down;
        freq_word_i <= next_req.word;
        in_valid_i  <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        stall_left = draw_stall();
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles   <= cycles + 1;
      in_fire  <= in_valid_i && !in_stall_o;
      out_fire <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        expected_freq_q.push_back(step_freq(knob_e'(req_type_i), step_down_i, freq_word_i));
        words_taken <= words_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_freq_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", new_freq_word_o));
        end else if (new_freq_word_o !== expected_freq_q[0]) begin
          report_mismatch($sformatf("new_freq_word %h, expected %h",
                                    new_freq_word_o, expected_freq_q[0]));
          void'(expected_freq_q.pop_front());
        end else begin
          void'(expected_freq_q.pop_front());
        end
      end
    end
  end

  initial begin
    knob_e                knob;
    logic [FreqWidth-1:0] word;
    int unsigned          shape;
    queue_req(KNOB_COM_MHZ,  1'b0, 16'h3650, 0, 1'b0);
    queue_req(KNOB_COM_MHZ,  1'b0, 16'h1995, 0, 1'b0);
    queue_req(KNOB_COM_MHZ,  1'b1, 16'h1800, 0, 1'b0);
    queue_req(KNOB_COM_MHZ,  1'b1, 16'h0000, 1, 1'b0);
    queue_req(KNOB_NAV_MHZ,  1'b0, 16'h1705, 0, 1'b0);
    queue_req(KNOB_NAV_MHZ,  1'b1, 16'h0850, 2, 1'b0);
    queue_req(KNOB_NAV_MHZ,  1'b0, 16'h0B00, 0, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b0, 16'h1297, 0, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b0, 16'h1202, 3, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b0, 16'h1204, 0, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b1, 16'h1300, 0, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b1, 16'h1310, 1, 1'b0);
    queue_req(KNOB_COM_FRAC, 1'b0, 16'h11A5, 0, 1'b0);
    queue_req(KNOB_NAV_FRAC, 1'b0, 16'h1195, 0, 1'b0);
    queue_req(KNOB_NAV_FRAC, 1'b0, 16'h1107, 0, 1'b0);
    queue_req(KNOB_NAV_FRAC, 1'b1, 16'h1100, 2, 1'b0);
    queue_req(KNOB_NAV_FRAC, 1'b1, 16'h1103, 0, 1'b0);
    queue_req(KNOB_NAV_FRAC, 1'b1, 16'h110C, 0, 1'b0);
    for (int k = 0; k < 8; k++) begin
      queue_req(knob_e'(k / 2), 1'(k % 2), 16'hFFFF, 0, 1'b0);
    end
    for (int n = 0; n < RandomWords; n++) begin
      knob  = knob_e'($urandom_range(0, 3));
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
        word = tuned_word(knob);
      end else if (shape < 9) begin
        word = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end else begin
        word = 16'($urandom_range(0, 65535));
      end
      queue_req(knob, 1'($urandom_range(0, 1)), word,
                ((n / 150) % 3 == 0) ? 0 : $urandom_range(0, 10), (n % 400) == 0);
    end
    wait (words_taken == words_total && expected_freq_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("radio_frequency_bcd_stepper verification clean");
    end else begin
      $display("radio_frequency_bcd_stepper verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rfbs_pkg.sv
sv/rfbs_step.sv
sv/radio_frequency_bcd_stepper.sv
bench/testbench.sv
